// ===== rtl/utf8_percent_unit_prefix_cutter_defines.svh =====
// Assertion macros for the UTF-8 / percent-escape prefix cutter.
// Used by the RTL files that carry checks; no other dependencies.
`ifndef UTF8_PERCENT_UNIT_PREFIX_CUTTER_DEFINES_SVH
`define UTF8_PERCENT_UNIT_PREFIX_CUTTER_DEFINES_SVH
`ifndef SYNTH
`define UPC_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("upc assertion failed");
`define UPC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("upc assertion failed");
`else
`define UPC_ASSERT(label, clk, rstn, prop)
`define UPC_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/upc_pkg.sv =====
// Shared types and constants for the UTF-8 / percent-escape prefix cutter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package upc_pkg;

  localparam int BUDGET_W = 11;
  localparam logic [BUDGET_W-1:0] BUDGET_RESET = 11'd235;

  // check that applies to the next byte of the open unit
  typedef enum logic [2:0] {
    KIND_NONE = 3'd0,
    KIND_PCT  = 3'd1,
    KIND_CONT = 3'd2,
    KIND_E0   = 3'd3,
    KIND_ED   = 3'd4,
    KIND_F0   = 3'd5,
    KIND_F4   = 3'd6,
    KIND_ANY  = 3'd7
  } kind_t;

  typedef struct packed {
    logic [1:0] left;
    kind_t      kind;
    logic       err;
  } unit_ctl_t;

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] LEAD2_LO = 8'hC2;
  localparam logic [7:0] LEAD2_HI = 8'hDF;
  localparam logic [7:0] LEAD_E0  = 8'hE0;
  localparam logic [7:0] LEAD_ED  = 8'hED;
  localparam logic [7:0] LEAD_EF  = 8'hEF;
  localparam logic [7:0] LEAD_F0  = 8'hF0;
  localparam logic [7:0] LEAD_F4  = 8'hF4;
  localparam logic [7:0] CONT_LO  = 8'h80;
  localparam logic [7:0] CONT_HI  = 8'hBF;
  localparam logic [7:0] E0_LO    = 8'hA0;
  localparam logic [7:0] ED_HI    = 8'h9F;
  localparam logic [7:0] F0_LO    = 8'h90;
  localparam logic [7:0] F4_HI    = 8'h8F;

  typedef enum logic {
    REG_BUDGET = 1'b0,
    REG_NONE   = 1'b1
  } reg_idx_t;

endpackage
`default_nettype wire

// ===== rtl/upc_step.sv =====
// Per-byte next-state logic of the prefix cutter: unit parsing, budget
// tracking and the end-of-string result. Depends on upc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module upc_step import upc_pkg::*; #(
  parameter int MAX_BYTES = 1024,
  parameter int OFF_W     = 11
) (
  input  wire logic [OFF_W-1:0]    off,
  input  wire logic [BUDGET_W-1:0] best,
  input  wire unit_ctl_t           ctl,
  input  wire logic [7:0]          data_byte,
  input  wire logic                last_byte,
  input  wire logic [BUDGET_W-1:0] budget,
  output logic [OFF_W-1:0]         off_nxt,
  output logic [BUDGET_W-1:0]      best_nxt,
  output unit_ctl_t                ctl_nxt,
  output logic [BUDGET_W-1:0]      keep_len,
  output logic                     malformed
);

  localparam int CMP_W = (OFF_W > BUDGET_W) ? OFF_W : BUDGET_W;
  localparam logic [OFF_W-1:0] MAX_OFF = OFF_W'(MAX_BYTES);

  logic             sat;
  logic [CMP_W-1:0] end_pos;
  logic             in_budget;
  logic             cont_ok;
  logic [OFF_W-1:0] off_s;
  logic [BUDGET_W-1:0] best_s;
  unit_ctl_t        ctl_s;
  logic             err_f;

  assign sat       = (off >= MAX_OFF);
  assign end_pos   = CMP_W'(off) + CMP_W'(1);
  assign in_budget = (end_pos <= CMP_W'(budget));

  always_comb begin
    case (ctl.kind)
      KIND_PCT: cont_ok = (data_byte >= 8'h30 && data_byte <= 8'h39) ||
                          (data_byte >= 8'h41 && data_byte <= 8'h46);
      KIND_E0:  cont_ok = (data_byte >= E0_LO && data_byte <= CONT_HI);
      KIND_ED:  cont_ok = (data_byte >= CONT_LO && data_byte <= ED_HI);
      KIND_F0:  cont_ok = (data_byte >= F0_LO && data_byte <= CONT_HI);
      KIND_F4:  cont_ok = (data_byte >= CONT_LO && data_byte <= F4_HI);
      KIND_CONT, KIND_ANY:
                cont_ok = (data_byte >= CONT_LO && data_byte <= CONT_HI);
      default:  cont_ok = 1'b0;
    endcase
  end

  always_comb begin
    ctl_s  = ctl;
    best_s = best;
    off_s  = sat ? off : off + OFF_W'(1);
    if (sat) begin
      ctl_s.err = 1'b1;
    end
    // bytes after an error are counted but not parsed
    if (!ctl_s.err) begin
      if (ctl.left == 2'd0) begin
        if (data_byte == CH_PCT) begin
          ctl_s.kind = KIND_PCT;
          ctl_s.left = 2'd2;
        end else if (data_byte < CONT_LO) begin
          if (in_budget) best_s = end_pos[BUDGET_W-1:0];
          ctl_s.kind = KIND_NONE;
        end else if (data_byte >= LEAD2_LO && data_byte <= LEAD2_HI) begin
          ctl_s.kind = KIND_CONT;
          ctl_s.left = 2'd1;
        end else if (data_byte == LEAD_E0) begin
          ctl_s.kind = KIND_E0;
          ctl_s.left = 2'd2;
        end else if (data_byte == LEAD_ED) begin
          ctl_s.kind = KIND_ED;
          ctl_s.left = 2'd2;
        end else if (data_byte > LEAD_E0 && data_byte <= LEAD_EF) begin
          ctl_s.kind = KIND_ANY;
          ctl_s.left = 2'd2;
        end else if (data_byte == LEAD_F0) begin
          ctl_s.kind = KIND_F0;
          ctl_s.left = 2'd3;
        end else if (data_byte == LEAD_F4) begin
          ctl_s.kind = KIND_F4;
          ctl_s.left = 2'd3;
        end else if (data_byte > LEAD_F0 && data_byte < LEAD_F4) begin
          ctl_s.kind = KIND_ANY;
          ctl_s.left = 2'd3;
        end else begin
          ctl_s.err = 1'b1;
        end
      end else if (cont_ok) begin
        ctl_s.left = ctl.left - 2'd1;
        if (ctl.kind != KIND_PCT) ctl_s.kind = KIND_CONT;
        if (ctl.left == 2'd1) begin
          if (in_budget) best_s = end_pos[BUDGET_W-1:0];
          ctl_s.kind = KIND_NONE;
        end
      end else begin
        ctl_s.err = 1'b1;
      end
    end
  end

  // a unit still open at the end is cut off
  assign err_f     = ctl_s.err | (ctl_s.left != 2'd0);
  assign malformed = err_f;
  assign keep_len  = err_f ? '0 : best_s;

  always_comb begin
    if (last_byte) begin
      ctl_nxt  = '{left: 2'd0, kind: KIND_NONE, err: 1'b0};
      best_nxt = '0;
      off_nxt  = '0;
    end else begin
      ctl_nxt  = ctl_s;
      best_nxt = best_s;
      off_nxt  = off_s;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/utf8_percent_unit_prefix_cutter.sv =====
// Channel    | Dir | Word contents
// in_        | in  | tdata[7:0] data_byte, tlast last_byte
// out_       | out | tdata[10:0] keep_len, tuser malformed
// cfg_       | in  | APB, reg 0 at 0x0: byte_budget[10:0]
// One byte per cycle sustained: a byte is held in the input register, then
// the step logic updates the running state and, on the last byte, loads
// the result register. A stall on out_ holds only a last byte in the input
// register; other bytes keep flowing. Reset (rst_n, synchronous) clears all
// parse state and sets byte_budget to 235.
// Top level of the UTF-8 / percent-escape prefix cutter.
// Depends on upc_pkg, upc_step and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_percent_unit_prefix_cutter_defines.svh"
module utf8_percent_unit_prefix_cutter import upc_pkg::*; #(
  parameter int MAX_BYTES = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,   // last_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [10:0] keep_len, rest zero
  output logic             out_tuser,  // malformed
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int OFF_W = $clog2(MAX_BYTES + 1);
  localparam logic [OFF_W-1:0] MAX_OFF = OFF_W'(MAX_BYTES);

  logic [BUDGET_W-1:0] budget_r;
  reg_idx_t            cfg_idx;

  logic                in_v_r;
  logic [7:0]          in_byte_r;
  logic                in_last_r;
  logic                fire;

  logic [OFF_W-1:0]    off_r, off_nxt;
  logic [BUDGET_W-1:0] best_r, best_nxt;
  unit_ctl_t           ctl_r, ctl_nxt;

  logic [BUDGET_W-1:0] res_len;
  logic                res_bad;
  logic                out_v_r;
  logic [BUDGET_W-1:0] out_len_r;
  logic                out_bad_r;

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[2]);

  always_comb begin
    case (cfg_idx)
      REG_BUDGET: cfg_prdata = {{(32-BUDGET_W){1'b0}}, budget_r};
      default:    cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r <= BUDGET_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_idx == REG_BUDGET) begin
      budget_r <= cfg_pwdata[BUDGET_W-1:0];
    end
  end

  // a last byte may only advance when the result register is free
  assign fire      = in_v_r && (!in_last_r || !out_v_r || out_tready);
  assign in_tready = !in_v_r || fire;

  upc_step #(
    .MAX_BYTES (MAX_BYTES),
    .OFF_W     (OFF_W)
  ) u_step (
    .off       (off_r),
    .best      (best_r),
    .ctl       (ctl_r),
    .data_byte (in_byte_r),
    .last_byte (in_last_r),
    .budget    (budget_r),
    .off_nxt   (off_nxt),
    .best_nxt  (best_nxt),
    .ctl_nxt   (ctl_nxt),
    .keep_len  (res_len),
    .malformed (res_bad)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      off_r   <= '0;
      best_r  <= '0;
      ctl_r   <= '{left: 2'd0, kind: KIND_NONE, err: 1'b0};
    end else begin
      if (in_tvalid && in_tready) begin
        in_v_r <= 1'b1;
      end else if (fire) begin
        in_v_r <= 1'b0;
      end
      if (fire) begin
        off_r  <= off_nxt;
        best_r <= best_nxt;
        ctl_r  <= ctl_nxt;
      end
      if (fire && in_last_r) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    if (fire && in_last_r) begin
      out_len_r <= res_len;
      out_bad_r <= res_bad;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(16-BUDGET_W){1'b0}}, out_len_r};
  assign out_tuser  = out_bad_r;

  `UPC_ASSERT(a_bad_zero_len, clk, rst_n, !(out_v_r && out_bad_r) || out_len_r == '0)
  `UPC_ASSERT(a_idle_kind, clk, rst_n, ctl_r.left != 2'd0 || ctl_r.kind == KIND_NONE)
  `UPC_ASSERT(a_off_bound, clk, rst_n, off_r <= MAX_OFF)
  `UPC_ASSERT_NEXT(a_last_clears, clk, rst_n, fire && in_last_r,
    off_r == '0 && best_r == '0 && !ctl_r.err && out_v_r)

endmodule
`default_nettype wire

// ===== tb/sv/utf8_percent_unit_prefix_cutter_test.sv =====
// Self-checking testbench for utf8_percent_unit_prefix_cutter: a byte stream in,
// one prefix-length / malformed word per string out, budget set over APB.
// Depends on upc_pkg and the block's RTL only.
`timescale 1ns / 1ps
module utf8_percent_unit_prefix_cutter_test;
  import upc_pkg::*;

  localparam int STR_MAX = 1024;
  localparam logic [2:0] BUDGET_ADDR = 3'(4 * int'(REG_BUDGET));
  localparam logic [7:0] DIG_LO = 8'h30;
  localparam logic [7:0] DIG_HI = 8'h39;
  localparam logic [7:0] HEX_LO = 8'h41;
  localparam logic [7:0] HEX_HI = 8'h46;

  typedef struct packed {
    logic [10:0] len;
    logic        mal;
  } cut_result_t;

  typedef struct packed {
    logic [7:0]  b;
    logic        is_last;
    logic        typed;
    logic [10:0] len;
    logic        mal;
  } row_t;

  // reset budget is 235, so every short string below fits whole
  localparam row_t DIRECTED_ROWS [22] = '{
    '{8'h41, 1'b1, 1'b1, 11'd1, 1'b0},
    '{8'h00, 1'b1, 1'b1, 11'd1, 1'b0},
    '{8'h25, 1'b1, 1'b1, 11'd0, 1'b1},
    '{8'h80, 1'b1, 1'b1, 11'd0, 1'b1},
    '{8'hFF, 1'b1, 1'b1, 11'd0, 1'b1},
    '{8'h25, 1'b0, 1'b0, 11'd0, 1'b0},
    '{8'h34, 1'b0, 1'b0, 11'd0, 1'b0},
    '{8'h46, 1'b1, 1'b1, 11'd3, 1'b0},
    '{8'hDF, 1'b0, 1'b0, 11'd0, 1'b0},
    '{8'hBF, 1'b1, 1'b1, 11'd2, 1'b0},
    '{8'hE0, 1'b0, 1'b0, 11'd0, 1'b0},
    '{8'hA0, 1'b0, 1'b0, 11'd0, 1'b0},
    '{8'h80, 1'b1, 1'b1, 11'd3, 1'b0},
    '{8'hED, 1'b0, 1'b0, 11'd0, 1'b0},
    '{8'hA0, 1'b0, 1'b0, 11'd0, 1'b0},
    '{8'h80, 1'b1, 1'b1, 11'd0, 1'b1},
    '{8'hF0, 1'b0, 1'b0, 11'd0, 1'b0},
    '{8'h90, 1'b0, 1'b0, 11'd0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 11'd0, 1'b0},
    '{8'h80, 1'b1, 1'b1, 11'd4, 1'b0},
    '{8'hF4, 1'b0, 1'b0, 11'd0, 1'b0},
    '{8'h90, 1'b1, 1'b1, 11'd0, 1'b1}
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] data_byte
  logic        in_tlast;   // last_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [10:0] keep_len, [15:11] zero
  logic        out_tuser;  // malformed
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  utf8_percent_unit_prefix_cutter #(.MAX_BYTES(STR_MAX)) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  cut_result_t prefix_q[$];
  int          mismatches = 0;
  bit          no_gaps = 1'b0;

  // shadow of the cutter's parse state
  logic [10:0] pr_budget;
  logic [10:0] pr_offset;
  logic [10:0] pr_best;
  logic [1:0]  pr_left;
  kind_t       pr_kind;
  bit          pr_err;

  function automatic void clear_cut();
    pr_offset = '0;
    pr_best   = '0;
    pr_left   = '0;
    pr_kind   = KIND_NONE;
    pr_err    = 1'b0;
  endfunction

  function automatic bit in_rng(logic [7:0] b, logic [7:0] lo, logic [7:0] hi);
    return b >= lo && b <= hi;
  endfunction

  function automatic bit follow_ok(kind_t k, logic [7:0] b);
    case (k)
      KIND_PCT:            return in_rng(b, DIG_LO, DIG_HI) || in_rng(b, HEX_LO, HEX_HI);
      KIND_E0:             return in_rng(b, E0_LO, CONT_HI);
      KIND_ED:             return in_rng(b, CONT_LO, ED_HI);
      KIND_F0:             return in_rng(b, F0_LO, CONT_HI);
      KIND_F4:             return in_rng(b, CONT_LO, F4_HI);
      KIND_CONT, KIND_ANY: return in_rng(b, CONT_LO, CONT_HI);
      default:             return 1'b0;
    endcase
  endfunction

  function automatic void close_unit(logic [10:0] stop);
    if (stop <= pr_budget) pr_best = stop;
    pr_kind = KIND_NONE;
  endfunction

  // advance the shadow state by one byte; returns 1 when a word is due
  function automatic bit cut_step(input logic [7:0] b, input bit is_last,
                                  output cut_result_t r);
    logic [10:0] pos;
    pos = pr_offset;
    r = '0;
    if (int'(pr_offset) >= STR_MAX) pr_err = 1'b1;
    else pr_offset = pr_offset + 11'd1;
    if (!pr_err) begin
      if (pr_left == 2'd0) begin
        if (b == CH_PCT) begin
          pr_kind = KIND_PCT; pr_left = 2'd2;
        end else if (b < CONT_LO) begin
          close_unit(pos + 11'd1);
        end else if (in_rng(b, LEAD2_LO, LEAD2_HI)) begin
          pr_kind = KIND_CONT; pr_left = 2'd1;
        end else if (b == LEAD_E0) begin
          pr_kind = KIND_E0; pr_left = 2'd2;
        end else if (b == LEAD_ED) begin
          pr_kind = KIND_ED; pr_left = 2'd2;
        end else if (in_rng(b, LEAD_E0, LEAD_EF)) begin
          pr_kind = KIND_ANY; pr_left = 2'd2;
        end else if (b == LEAD_F0) begin
          pr_kind = KIND_F0; pr_left = 2'd3;
        end else if (b == LEAD_F4) begin
          pr_kind = KIND_F4; pr_left = 2'd3;
        end else if (in_rng(b, LEAD_F0, LEAD_F4)) begin
          pr_kind = KIND_ANY; pr_left = 2'd3;
        end else begin
          pr_err = 1'b1;
        end
      end else if (follow_ok(pr_kind, b)) begin
        pr_left = pr_left - 2'd1;
        if (pr_kind != KIND_PCT) pr_kind = KIND_CONT;
        if (pr_left == 2'd0) close_unit(pos + 11'd1);
      end else begin
        pr_err = 1'b1;
      end
    end
    if (!is_last) return 1'b0;
    // a unit still open at the end is cut off
    if (pr_left != 2'd0) pr_err = 1'b1;
    r.len = pr_err ? 11'd0 : pr_best;
    r.mal = pr_err;
    clear_cut();
    return 1'b1;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic logic [7:0] ascii_byte();
    logic [7:0] a;
    a = 8'($urandom_range(0, 127));
    return (a == CH_PCT) ? 8'h00 : a;
  endfunction

  function automatic logic [7:0] pick(logic [7:0] lo, logic [7:0] hi);
    return 8'($urandom_range(int'(hi), int'(lo)));
  endfunction

  function automatic logic [7:0] hex_digit();
    int d;
    d = $urandom_range(0, 15);
    return (d < 10) ? DIG_LO + 8'(d) : HEX_LO + 8'(d - 10);
  endfunction

  // append one well-formed unit with random content
  function automatic void add_unit(ref logic [7:0] s[$]);
    logic [7:0] a;
    case ($urandom_range(0, 11))
      0, 1, 2: s.push_back(ascii_byte());
      3: begin
        s.push_back(CH_PCT); s.push_back(hex_digit()); s.push_back(hex_digit());
      end
      4, 5: begin
        s.push_back(pick(LEAD2_LO, LEAD2_HI)); s.push_back(pick(CONT_LO, CONT_HI));
      end
      6: begin
        s.push_back(LEAD_E0); s.push_back(pick(E0_LO, CONT_HI));
        s.push_back(pick(CONT_LO, CONT_HI));
      end
      7: begin
        s.push_back(LEAD_ED); s.push_back(pick(CONT_LO, ED_HI));
        s.push_back(pick(CONT_LO, CONT_HI));
      end
      8: begin
        a = pick(LEAD_E0 + 8'd1, LEAD_EF);
        if (a == LEAD_ED) a = LEAD_EF;
        s.push_back(a); s.push_back(pick(CONT_LO, CONT_HI));
        s.push_back(pick(CONT_LO, CONT_HI));
      end
      9: begin
        s.push_back(LEAD_F0); s.push_back(pick(F0_LO, CONT_HI));
        repeat (2) s.push_back(pick(CONT_LO, CONT_HI));
      end
      10: begin
        s.push_back(pick(LEAD_F0 + 8'd1, LEAD_F4 - 8'd1));
        repeat (3) s.push_back(pick(CONT_LO, CONT_HI));
      end
      default: begin
        s.push_back(LEAD_F4); s.push_back(pick(CONT_LO, F4_HI));
        repeat (2) s.push_back(pick(CONT_LO, CONT_HI));
      end
    endcase
  endfunction

  task automatic idle_in();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // offer one byte, wait for the handshake, then predict
  task automatic send_byte(input logic [7:0] b, input bit is_last,
                           input bit typed, input cut_result_t typed_res);
    int gap;
    cut_result_t r;
    gap = no_gaps ? 0 : gap_len();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= is_last;
    do @(posedge clk); while (!in_tready);
    if (cut_step(b, is_last, r)) prefix_q.push_back(typed ? typed_res : r);
  endtask

  task automatic drain();
    while (prefix_q.size() != 0) @(posedge clk);
  endtask

  // write the budget while idle, then read it back
  task automatic set_budget(input logic [10:0] v);
    idle_in();
    drain();
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= BUDGET_ADDR;
    cfg_pwdata  <= {21'd0, v};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    pr_budget = v;
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[10:0] !== v) begin
      $error("byte_budget readback: expected %0d, got %0d", v, cfg_prdata[10:0]);
      mismatches++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // receiver: random stalls, none while no_gaps is set
  initial begin : rx_side
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0 && !no_gaps) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        stall_left = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      end
    end
  end

  always @(posedge clk) begin
    cut_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (prefix_q.size() == 0) begin
        $error("result word with nothing expected: keep_len %0d, malformed %0b",
               out_tdata[10:0], out_tuser);
        mismatches++;
      end else begin
        want = prefix_q.pop_front();
        if (out_tdata[10:0] !== want.len) begin
          $error("keep_len: expected %0d, got %0d", want.len, out_tdata[10:0]);
          mismatches++;
        end
        if (out_tuser !== want.mal) begin
          $error("malformed: expected %0b, got %0b", want.mal, out_tuser);
          mismatches++;
        end
        if (out_tdata[15:11] !== 5'd0) begin
          $error("out_tdata pad: expected 0, got %0h", out_tdata[15:11]);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    int phase, sent, strings, n, k;
    logic [10:0] bud;
    logic [7:0] s[$];
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    pr_budget   = BUDGET_RESET;
    clear_cut();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED_ROWS[i])
      send_byte(DIRECTED_ROWS[i].b, DIRECTED_ROWS[i].is_last, DIRECTED_ROWS[i].typed,
                '{DIRECTED_ROWS[i].len, DIRECTED_ROWS[i].mal});

    strings = 0;
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        1:       bud = 11'd0;
        2:       bud = 11'd1024;
        3:       bud = 11'd1;
        5:       bud = 11'd1023;
        default: bud = 11'($urandom_range(2, 30));
      endcase
      set_budget(bud);
      no_gaps = (phase == 4);
      sent = 0;
      while (sent < 30) begin
        s.delete();
        if ($urandom_range(0, 9) == 0) begin
          // noise
          n = $urandom_range(1, 8);
          repeat (n) s.push_back(8'($urandom_range(0, 255)));
        end else begin
          n = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
          repeat (n) add_unit(s);
          if ($urandom_range(0, 4) == 0) begin
            // break the string: bad byte, cut-off tail, or dangling lead
            k = $urandom_range(0, 2);
            if (k == 0) s[$urandom_range(0, s.size() - 1)] = 8'($urandom_range(0, 255));
            else if (k == 1 && s.size() > 1) void'(s.pop_back());
            else s.push_back(($urandom_range(0, 1) == 0) ? CH_PCT : pick(LEAD2_LO, 8'hFF));
          end
        end
        foreach (s[i]) send_byte(s[i], i == s.size() - 1, 1'b0, '0);
        sent += s.size();
        strings++;
        if (phase == 6 && strings % 2 == 0) begin
          idle_in();
          drain();
        end
      end
    end
    no_gaps = 1'b0;

    // length limit: one byte past STR_MAX overflows
    set_budget(11'd1024);
    for (k = 0; k < STR_MAX + 1; k++) send_byte(ascii_byte(), k == STR_MAX, 1'b0, '0);

    idle_in();
    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("utf8_percent_unit_prefix_cutter_test OK");
    end else begin
      $display("utf8_percent_unit_prefix_cutter_test NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("utf8_percent_unit_prefix_cutter_test NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/upc_pkg.sv
rtl/upc_step.sv
rtl/utf8_percent_unit_prefix_cutter.sv
tb/sv/utf8_percent_unit_prefix_cutter_test.sv
